// ----- design/gbn_pkg.sv -----
`timescale 1ns / 1ps

package gbn_pkg;

	// fixed field widths
	localparam int OPCODE_W  = 2;
	localparam int PAYLOAD_W = 32;
	localparam int TCMD_W    = 2;

	// defaults for the top-level parameters
	localparam int DEF_SEQ_SPACE = 8;
	localparam int DEF_WINDOW    = 4;

	// request kinds
	localparam logic [OPCODE_W-1:0] OP_SEND    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ACK     = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TIMEOUT = 2'd2;

	// timer commands
	localparam logic [TCMD_W-1:0] TMR_NONE    = 2'd0;
	localparam logic [TCMD_W-1:0] TMR_START   = 2'd1;
	localparam logic [TCMD_W-1:0] TMR_STOP    = 2'd2;
	localparam logic [TCMD_W-1:0] TMR_RESTART = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_READ = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

// ----- design/go_back_n_sender.sv -----
`timescale 1ns / 1ps

// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+--------------------------------------------
// request  | in  | s_axis_tvalid / tready | tuser: opcode; tdata: payload, ack_number,
//          |     |                        |   ack_checksum_ok
// result   | out | m_axis_tvalid / tready | tdata: result fields; tlast: last
//
// A send or an ack is accepted, then executed; a timeout is accepted, executed and,
// for N buffered packets, walks them with one payload RAM read (ST_READ) and one
// result (ST_EMIT) per packet. The RAM's registered read port sets the retransmit pace.
// Intake stays closed from accept until the last result of a request is loaded
// into the output register; a stalled result holds the sequencer.
// Reset (arst_n low) empties the window; payload RAM contents are not cleared.
module go_back_n_sender #(
	parameter int SEQ_SPACE = gbn_pkg::DEF_SEQ_SPACE,
	parameter int WINDOW    = gbn_pkg::DEF_WINDOW,
	localparam int SEQ_W    = $clog2(SEQ_SPACE),
	localparam int IN_W     = gbn_pkg::PAYLOAD_W + SEQ_W + 1,
	localparam int IN_DW    = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W    = 3 + 2 * SEQ_W + gbn_pkg::PAYLOAD_W + gbn_pkg::TCMD_W,
	localparam int OUT_DW   = ((OUT_W + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// payload, ack_number, ack_checksum_ok (from bit 0 up), zero padded
	input  logic [IN_DW-1:0]            s_axis_tdata,
	// opcode
	input  logic [gbn_pkg::OPCODE_W-1:0] s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// accepted, packet_valid, packet_seq, packet_payload, timer_command,
	// timer_tag, window_full (from bit 0 up), zero padded
	output logic [OUT_DW-1:0]           m_axis_tdata,
	output logic                        m_axis_tlast
);

	import gbn_pkg::*;

	localparam int CAP    = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE - 1;
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int RING_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int RS_W   = RING_W + 1;
	localparam int SQ_W   = SEQ_W + 1;

	// modulo-SEQ_SPACE increment
	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v);
		logic [SQ_W-1:0] s;
		s = SQ_W'(v) + SQ_W'(1);
		if (s >= SQ_W'(SEQ_SPACE)) begin
			s = '0;
		end
		return s[SEQ_W-1:0];
	endfunction

	// ring slot plus a step of at most WINDOW, modulo WINDOW
	function automatic logic [RING_W-1:0] ring_add(input logic [RING_W-1:0] v,
	                                               input logic [CNT_W-1:0] n);
		logic [RS_W-1:0] s;
		s = RS_W'(v) + RS_W'(n);
		if (s >= RS_W'(WINDOW)) begin
			s = s - RS_W'(WINDOW);
		end
		return s[RING_W-1:0];
	endfunction

	state_t state_q, state_d;

	// window state
	logic [SEQ_W-1:0]  base_q, base_d;
	logic [SEQ_W-1:0]  next_q, next_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [RING_W-1:0] head_q, head_d;

	// latched request
	logic [OPCODE_W-1:0]  op_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic [SEQ_W-1:0]     ack_q;
	logic                 ok_q;

	// retransmit walker
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [SEQ_W-1:0]  rseq_q, rseq_d;
	logic [RING_W-1:0] rslot_q, rslot_d;

	// output register
	logic                 m_valid_q;
	logic                 acc_q, pv_q, wf_q, last_q;
	logic [SEQ_W-1:0]     seq_q, tag_q;
	logic [PAYLOAD_W-1:0] opay_q;
	logic [TCMD_W-1:0]    tcmd_q;

	// next result
	logic                 load_out;
	logic                 o_acc, o_pv, o_wf, o_last;
	logic [SEQ_W-1:0]     o_seq, o_tag;
	logic [PAYLOAD_W-1:0] o_pay;
	logic [TCMD_W-1:0]    o_tcmd;

	logic                 out_free;
	logic                 in_fire;
	logic                 ram_we;
	logic [RING_W-1:0]    ram_waddr;
	logic [PAYLOAD_W-1:0] ram_rdata;

	// ack arithmetic
	logic [SQ_W-1:0]  ack_gap;
	logic             ack_hit;
	logic [CNT_W-1:0] drop;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = OUT_DW'({wf_q, tag_q, tcmd_q, opay_q, seq_q, pv_q, acc_q});

	// distance of the acked number from base, modulo SEQ_SPACE
	always_comb begin
		if (ack_q >= base_q) begin
			ack_gap = SQ_W'(ack_q) - SQ_W'(base_q);
		end else begin
			ack_gap = SQ_W'(ack_q) + SQ_W'(SEQ_SPACE) - SQ_W'(base_q);
		end
		ack_hit = (SQ_W'(ack_q) < SQ_W'(SEQ_SPACE)) && (ack_gap < SQ_W'(count_q));
		drop    = ack_gap[CNT_W-1:0] + CNT_W'(1);
	end

	assign ram_waddr = ring_add(head_q, count_q);

	gbn_ram #(
		.WIDTH(PAYLOAD_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(pay_q),
		.raddr(rslot_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d  = state_q;
		base_d   = base_q;
		next_d   = next_q;
		count_d  = count_q;
		head_d   = head_q;
		idx_d    = idx_q;
		rseq_d   = rseq_q;
		rslot_d  = rslot_q;
		ram_we   = 1'b0;
		load_out = 1'b0;
		o_acc    = 1'b0;
		o_pv     = 1'b0;
		o_seq    = '0;
		o_pay    = '0;
		o_tcmd   = TMR_NONE;
		o_tag    = '0;
		o_wf     = (count_q >= CNT_W'(CAP));
		o_last   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (s_axis_tuser)
						OP_SEND, OP_ACK, OP_TIMEOUT: state_d = ST_EXEC;
						default:                     state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
					unique case (op_q)
						OP_SEND: begin
							load_out = 1'b1;
							if (count_q < CNT_W'(CAP)) begin
								ram_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
								next_d  = seq_inc(next_q);
								o_acc   = 1'b1;
								o_pv    = 1'b1;
								o_seq   = next_q;
								o_pay   = pay_q;
								if (count_q == '0) begin
									o_tcmd = TMR_START;
									o_tag  = base_q;
								end
								o_wf = (count_d >= CNT_W'(CAP));
							end
						end
						OP_ACK: begin
							load_out = 1'b1;
							if (ok_q) begin
								if (ack_hit) begin
									count_d = count_q - drop;
									head_d  = ring_add(head_q, drop);
									base_d  = seq_inc(ack_q);
								end
								if (count_d != '0) begin
									o_tcmd = TMR_RESTART;
									o_tag  = base_d;
								end else begin
									o_tcmd = TMR_STOP;
									o_tag  = base_q;
								end
								o_wf = (count_d >= CNT_W'(CAP));
							end
						end
						OP_TIMEOUT: begin
							if (count_q == '0) begin
								load_out = 1'b1;
								o_tcmd   = TMR_RESTART;
								o_tag    = base_q;
							end else begin
								idx_d   = '0;
								rseq_d  = base_q;
								rslot_d = head_q;
								state_d = ST_READ;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				// RAM read of rslot_q lands at the end of this cycle
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					o_pv     = 1'b1;
					o_seq    = rseq_q;
					o_pay    = ram_rdata;
					if (idx_q == '0) begin
						o_tcmd = TMR_RESTART;
						o_tag  = base_q;
					end
					o_last  = (idx_q == count_q - CNT_W'(1));
					idx_d   = idx_q + CNT_W'(1);
					rseq_d  = seq_inc(rseq_q);
					rslot_d = ring_add(rslot_q, CNT_W'(1));
					state_d = o_last ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= '0;
			next_q    <= '0;
			count_q   <= '0;
			head_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			base_q  <= base_d;
			next_q  <= next_d;
			count_q <= count_d;
			head_q  <= head_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_axis_tuser;
			pay_q <= s_axis_tdata[PAYLOAD_W-1:0];
			ack_q <= s_axis_tdata[PAYLOAD_W +: SEQ_W];
			ok_q  <= s_axis_tdata[PAYLOAD_W + SEQ_W];
		end
		idx_q   <= idx_d;
		rseq_q  <= rseq_d;
		rslot_q <= rslot_d;
		if (load_out) begin
			acc_q  <= o_acc;
			pv_q   <= o_pv;
			seq_q  <= o_seq;
			opay_q <= o_pay;
			tcmd_q <= o_tcmd;
			tag_q  <= o_tag;
			wf_q   <= o_wf;
			last_q <= o_last;
		end
	end

endmodule

// ----- design/gbn_ram.sv -----
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module gbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
